/* hw/rtl/xlb_pkg.sv */
// ----------------------------------------------------------------------------
// xlb_pkg
// Shared types and constants of the GF(2) linear basis unit.
// ----------------------------------------------------------------------------
package xlb_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 64;
	localparam int RANK_W  = 6;

	// Code 7 has no member; it falls into the default arms.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_MAX_XOR  = 3'd1,
		OP_MIN_XOR  = 3'd2,
		OP_CONTAINS = 3'd3,
		OP_KTH      = 3'd4,
		OP_COUNT_LT = 3'd5,
		OP_COUNT_LE = 3'd6
	} op_t;

	typedef struct packed {
		logic start;   // load operands, point at the top row
		logic issue;   // read one row and step the row index down
		logic finish;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic last;    // row index is at row zero
	} status_t;

endpackage

/* hw/rtl/xlb_in_if.sv */
// ----------------------------------------------------------------------------
// xlb_in_if
// Request channel: operation code and 64-bit operand.
// ----------------------------------------------------------------------------
interface xlb_in_if;
	logic                               valid;
	logic                               ready;
	logic [xlb_pkg::OP_W-1:0]           operation;
	logic signed [xlb_pkg::VALUE_W-1:0] operand;

	modport source(output valid, output operation, output operand, input ready);
	modport sink(input valid, input operation, input operand, output ready);
endinterface

/* hw/rtl/xlb_out_if.sv */
// ----------------------------------------------------------------------------
// xlb_out_if
// Response channel: value, flag and rank after the operation.
// ----------------------------------------------------------------------------
interface xlb_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [xlb_pkg::VALUE_W-1:0] value;
	logic                               flag;
	logic [xlb_pkg::RANK_W-1:0]         rank;

	modport source(output valid, output value, output flag, output rank, input ready);
	modport sink(input valid, input value, input flag, input rank, output ready);
endinterface

/* hw/rtl/xlb_ctrl.sv */
// ----------------------------------------------------------------------------
// xlb_ctrl
// Sequencer: accepts a request, walks all rows, then hands off the result.
// ----------------------------------------------------------------------------
module xlb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  xlb_pkg::status_t status,
	output xlb_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TAIL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = out_valid_q;
	assign cmd.start  = (state_q == ST_IDLE) && req_valid;
	assign cmd.issue  = (state_q == ST_WALK);
	assign cmd.finish = (state_q == ST_FIN) && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (status.last) state_q <= ST_TAIL;
				end
				ST_TAIL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("response valid without a finished transaction");

	a_tail_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |=> (state_q == ST_FIN))
		else $error("last row step not followed by finish");

	a_start_walks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_WALK))
		else $error("accepted transaction did not start the walk");

endmodule

/* hw/rtl/xlb_dp.sv */
// ----------------------------------------------------------------------------
// xlb_dp
// Datapath: basis row memory, rank, one row step per cycle, output register.
// ----------------------------------------------------------------------------
module xlb_dp #(
	parameter int BITS = 60
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  xlb_pkg::cmd_t                      cmd,
	output xlb_pkg::status_t                   status,
	input  logic [xlb_pkg::OP_W-1:0]           operation,
	input  logic signed [xlb_pkg::VALUE_W-1:0] operand,
	output logic signed [xlb_pkg::VALUE_W-1:0] value,
	output logic                               flag,
	output logic [xlb_pkg::RANK_W-1:0]         rank
);

	localparam int IW = (BITS > 1) ? $clog2(BITS) : 1;
	localparam logic [IW-1:0] TOP_IDX = IW'(BITS - 1);
	localparam int VW = xlb_pkg::VALUE_W;
	localparam int RW = xlb_pkg::RANK_W;

	// basis rows; an entry with its valid bit clear reads as empty
	logic [VW-1:0]   mem [BITS];
	logic [BITS-1:0] vld_q;
	logic [RW-1:0]   rank_q;

	xlb_pkg::op_t op_q;
	logic [VW-1:0] x_q;     // operand, or k for kth
	logic [VW-1:0] acc_q;   // working vector / prefix element
	logic [VW-1:0] red_q;   // operand reduced toward minimum
	logic [VW-1:0] cnt_q;   // span size below the current row
	logic [VW-1:0] ret_q;   // running count
	logic          done_q;
	logic          flag_q;
	logic          kbad_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          step_s1;
	logic          rvld_s1;
	logic [VW-1:0] rdata_s1;

	logic [VW-1:0] value_q;
	logic          flag_out_q;
	logic [RW-1:0] rank_out_q;

	logic [VW-1:0] cnt_init;
	logic          x_neg;
	logic          x_high;
	logic          is_count;
	logic [5:0]    bi;
	logic          ab;
	logic          xb;
	logic          rb;
	logic [VW-1:0] half;
	logic          kgt;
	logic          want;
	logic [VW-1:0] ret_sum;
	logic [VW-1:0] k_sub;
	logic          wr_en;

	always_comb begin
		cnt_init = VW'(1) << rank_q;
		x_neg    = operand[VW-1];
		x_high   = (operand[VW-2:BITS] != '0);
		is_count = (operation == xlb_pkg::OP_COUNT_LT) || (operation == xlb_pkg::OP_COUNT_LE);
		bi       = 6'(idx_s1);
		ab       = acc_q[bi];
		xb       = x_q[bi];
		rb       = red_q[bi];
		half     = cnt_q >> 1;
		kgt      = x_q > half;
		want     = (op_q == xlb_pkg::OP_KTH) ? kgt : xb;
		ret_sum  = ret_q + (rvld_s1 ? half : cnt_q);
		k_sub    = x_q - half;
		wr_en    = step_s1 && (op_q == xlb_pkg::OP_INSERT) && !done_q && ab && !rvld_s1;
	end

	assign status.last = (idx_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) mem[idx_s1] <= acc_q;
		rdata_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rank_q  <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= cmd.issue;
			if (wr_en) begin
				vld_q[idx_s1] <= 1'b1;
				rank_q        <= rank_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		rvld_s1 <= vld_q[idx_q];
		if (cmd.start) begin
			idx_q <= TOP_IDX;
		end else if (cmd.issue) begin
			idx_q <= idx_q - IW'(1);
		end

		if (cmd.start) begin
			op_q   <= xlb_pkg::op_t'(operation);
			x_q    <= operand;
			red_q  <= operand;
			acc_q  <= (operation == xlb_pkg::OP_KTH || is_count) ? '0 : operand;
			cnt_q  <= cnt_init;
			ret_q  <= (!x_neg && x_high) ? cnt_init : '0;
			done_q <= is_count && (x_neg || x_high);
			flag_q <= 1'b0;
			kbad_q <= x_neg || (operand == '0) || (operand > cnt_init);
		end else if (step_s1) begin
			if (rvld_s1 && rb) red_q <= red_q ^ rdata_s1;
			case (op_q)
				xlb_pkg::OP_INSERT: begin
					if (wr_en) begin
						done_q <= 1'b1;
						flag_q <= 1'b1;
					end else if (!done_q && ab) begin
						acc_q <= acc_q ^ rdata_s1;
					end
				end
				xlb_pkg::OP_MAX_XOR: begin
					if (rvld_s1 && !ab) acc_q <= acc_q ^ rdata_s1;
				end
				xlb_pkg::OP_MIN_XOR, xlb_pkg::OP_CONTAINS: begin
					if (rvld_s1 && ab) acc_q <= acc_q ^ rdata_s1;
				end
				xlb_pkg::OP_KTH: begin
					if (rvld_s1) begin
						if (want != ab) acc_q <= acc_q ^ rdata_s1;
						if (kgt) x_q <= k_sub;
						cnt_q <= half;
					end
				end
				xlb_pkg::OP_COUNT_LT, xlb_pkg::OP_COUNT_LE: begin
					if (!done_q) begin
						if (rvld_s1) begin
							if (xb) ret_q <= ret_sum;
							if (want != ab) acc_q <= acc_q ^ rdata_s1;
							cnt_q <= half;
						end else if (xb ^ ab) begin
							// empty row decides the comparison
							if (xb) ret_q <= ret_sum;
							done_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (cmd.finish) begin
			rank_out_q <= rank_q;
			case (op_q)
				xlb_pkg::OP_MAX_XOR, xlb_pkg::OP_MIN_XOR: value_q <= acc_q;
				xlb_pkg::OP_KTH:      value_q <= kbad_q ? '1 : acc_q;
				xlb_pkg::OP_COUNT_LT: value_q <= ret_q;
				xlb_pkg::OP_COUNT_LE: value_q <= ret_q + VW'(red_q == '0);
				default:              value_q <= '0;
			endcase
			case (op_q)
				xlb_pkg::OP_INSERT:   flag_out_q <= flag_q;
				xlb_pkg::OP_CONTAINS: flag_out_q <= (red_q == '0);
				default:              flag_out_q <= 1'b0;
			endcase
		end
	end

	assign value = value_q;
	assign flag  = flag_out_q;
	assign rank  = rank_out_q;

	a_write_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !vld_q[idx_s1])
		else $error("insert overwrote a nonempty row");

	a_write_lead_bit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> acc_q[bi])
		else $error("stored row lacks its leading bit");

	a_rank_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q == RW'($countones(vld_q)))
		else $error("rank differs from number of filled rows");

endmodule

/* hw/rtl/xor_linear_basis_unit.sv */
// ----------------------------------------------------------------------------
// xor_linear_basis_unit
// GF(2) linear basis of up to BITS rows with insert and span queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an operation code and a 64-bit operand; rsp returns value,
//   flag and the rank after the operation, one response per request, in
//   order. Both channels move a transaction when valid and ready are high.
//   Every request walks all BITS rows from the top down, one row read from
//   the row memory per cycle. After the walk the sequencer passes a tail
//   state and a finish state; the response turns valid and req.ready returns
//   in the same cycle, so a request is taken only once the last one is done.
//   The result sits in an output register: the next request is accepted
//   while it waits. If rsp stalls when a second result is ready, the block
//   holds that result and takes no new request until the register frees.
//   Reset clears all rows (per-row valid bits) and the rank at once; no
//   clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module xor_linear_basis_unit #(
	parameter int BITS = 60
) (
	input logic       clk,
	input logic       arst_n,
	xlb_in_if.sink    req,
	xlb_out_if.source rsp
);

	xlb_pkg::cmd_t    cmd;
	xlb_pkg::status_t status;

	xlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	xlb_dp #(
		.BITS (BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.operation (req.operation),
		.operand   (req.operand),
		.value     (rsp.value),
		.flag      (rsp.flag),
		.rank      (rsp.rank)
	);

endmodule
